// ----- hdl/sne_pkg.sv -----
// Shared constants, gradient decode and helper functions for the simplex noise evaluator.
`timescale 1ns / 1ps
`default_nettype none
package sne_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int TAB_AW = $clog2(TABLE_SIZE);
	localparam int NUM_DIM = 4;
	localparam int NUM_CORNER = NUM_DIM + 1;
	localparam int NUM_LEVEL = NUM_DIM;

	// skew factors, Q0.30
	localparam logic [28:0] SKEW_F2 = 29'd393016785;
	localparam logic [28:0] SKEW_F3 = 29'd357913941;
	localparam logic [28:0] SKEW_F4 = 29'd331804471;

	// unskew factors, Q0.40
	localparam logic [37:0] UNSKEW_G2 = 38'd232354146751;
	localparam logic [37:0] UNSKEW_G3 = 38'd183251937963;
	localparam logic [37:0] UNSKEW_G4 = 38'd151948769856;

	// output scale per dimension count
	localparam logic [6:0] SCALE_2D = 7'd70;
	localparam logic [6:0] SCALE_3D = 7'd32;
	localparam logic [6:0] SCALE_4D = 7'd27;

	// dimension select codes
	localparam logic [1:0] SEL_2D = 2'd0;
	localparam logic [1:0] SEL_3D = 2'd1;
	localparam logic [1:0] SEL_4D = 2'd2;

	// operation codes
	localparam logic OP_EVAL = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// gradient with components in {-1, 0, +1}: nonzero mask and sign mask
	typedef struct packed {
		logic [3:0] nz;
		logic [3:0] neg;
	} grad_t;

	// reduce an 8-bit hash modulo 12 by conditional subtraction
	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [7:0] r;
		r = h;
		if (r >= 8'd192) r = r - 8'd192;
		if (r >= 8'd96) r = r - 8'd96;
		if (r >= 8'd48) r = r - 8'd48;
		if (r >= 8'd24) r = r - 8'd24;
		if (r >= 8'd12) r = r - 8'd12;
		return r[3:0];
	endfunction

	// decode a hash into its gradient: 32 hypercube edges in 4D, 12 cube edges otherwise
	function automatic grad_t grad_lookup(input logic [7:0] h, input logic is4d);
		grad_t g;
		logic [3:0] m;
		g.nz = 4'b0000;
		g.neg = 4'b0000;
		m = mod12(h);
		if (is4d) begin
			unique case (h[4:3])
				2'd0: begin
					g.nz = 4'b1110;
					g.neg = {h[0], h[1], h[2], 1'b0};
				end
				2'd1: begin
					g.nz = 4'b1101;
					g.neg = {h[0], h[1], 1'b0, h[2]};
				end
				2'd2: begin
					g.nz = 4'b1011;
					g.neg = {h[0], 1'b0, h[1], h[2]};
				end
				default: begin
					g.nz = 4'b0111;
					g.neg = {1'b0, h[0], h[1], h[2]};
				end
			endcase
		end else begin
			unique case (m[3:2])
				2'd0: begin
					g.nz = 4'b0011;
					g.neg = {2'b00, m[1], m[0]};
				end
				2'd1: begin
					g.nz = 4'b0101;
					g.neg = {1'b0, m[1], 1'b0, m[0]};
				end
				2'd2: begin
					g.nz = 4'b0110;
					g.neg = {1'b0, m[1], m[0], 1'b0};
				end
				default: begin
					g.nz = 4'b0000;
					g.neg = 4'b0000;
				end
			endcase
		end
		return g;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/simplex_noise_eval_top.sv -----
// Simplex noise evaluator top level: skew, rank, hash, falloff and scale pipeline.
// Throughput: one item per cycle while the output is not stalled; every stage is a register
// stage and the permutation table is held in 20 copies, one per corner and hash level.
// A load travels down the pipeline and writes each table copy at its read stage.
// Reset clears valid bits and sets dimensions to 2; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module simplex_noise_eval_top
	import sne_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [31:0] z_coord,
	input  logic signed [31:0] w_coord,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);

	localparam logic REG_DIMENSIONS = 1'b0;
	localparam logic signed [39:0] ONE_Q32 = 40'sh01_0000_0000;
	localparam logic signed [39:0] NEG_ONE_Q32 = -40'sh01_0000_0000;
	localparam logic [62:0] HALF_Q60 = 63'h0800_0000_0000_0000;

	// ---------------- configuration ----------------
	logic [2:0] dimensions_q;
	logic [1:0] sel;
	logic [2:0] n_val;
	logic [3:0] use_d;
	logic [4:0] ex_k;
	logic [28:0] f_sel;
	logic [37:0] g_sel;
	logic [6:0] scale_sel;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIMENSIONS) ? {29'd0, dimensions_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q <= 3'd2;
		end else if (psel && penable && pwrite && paddr[2] == REG_DIMENSIONS) begin
			dimensions_q <= pwdata[2:0];
		end
	end

	// clamp the dimension count and pick the constants
	always_comb begin
		if (dimensions_q <= 3'd2) sel = SEL_2D;
		else if (dimensions_q == 3'd3) sel = SEL_3D;
		else sel = SEL_4D;
		n_val = 3'(sel) + 3'd2;
		use_d = {sel == SEL_4D, sel != SEL_2D, 2'b11};
		ex_k = {sel == SEL_4D, sel != SEL_2D, 3'b111};
		unique case (sel)
			SEL_2D: begin
				f_sel = SKEW_F2;
				g_sel = UNSKEW_G2;
				scale_sel = SCALE_2D;
			end
			SEL_3D: begin
				f_sel = SKEW_F3;
				g_sel = UNSKEW_G3;
				scale_sel = SCALE_3D;
			end
			default: begin
				f_sel = SKEW_F4;
				g_sel = UNSKEW_G4;
				scale_sel = SCALE_4D;
			end
		endcase
	end

	// ---------------- pipeline control ----------------
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic ev_s11, ev_s12, ev_s13, ev_s14, ev_s15, ev_s16;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7, ld_s8, ld_s9, ld_s10;

	// advance valid bits and operation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0;
			ev_s11 <= 1'b0; ev_s12 <= 1'b0; ev_s13 <= 1'b0; ev_s14 <= 1'b0;
			ev_s15 <= 1'b0; ev_s16 <= 1'b0;
			ld_s1 <= 1'b0; ld_s2 <= 1'b0; ld_s3 <= 1'b0; ld_s4 <= 1'b0;
			ld_s5 <= 1'b0; ld_s6 <= 1'b0; ld_s7 <= 1'b0; ld_s8 <= 1'b0;
			ld_s9 <= 1'b0; ld_s10 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= vld_s7;
			vld_s9 <= vld_s8; vld_s10 <= vld_s9;
			ld_s1 <= (operation == OP_LOAD); ld_s2 <= ld_s1; ld_s3 <= ld_s2;
			ld_s4 <= ld_s3; ld_s5 <= ld_s4; ld_s6 <= ld_s5; ld_s7 <= ld_s6;
			ld_s8 <= ld_s7; ld_s9 <= ld_s8; ld_s10 <= ld_s9;
			ev_s11 <= vld_s10 && !ld_s10;
			ev_s12 <= ev_s11; ev_s13 <= ev_s12; ev_s14 <= ev_s13;
			ev_s15 <= ev_s14; ev_s16 <= ev_s15;
			out_valid <= ev_s16;
		end
	end

	// ---------------- load payload ----------------
	logic [7:0] tidx_s1, tidx_s2, tidx_s3, tidx_s4, tidx_s5;
	logic [7:0] tidx_s6, tidx_s7, tidx_s8, tidx_s9, tidx_s10;
	logic [7:0] tval_s1, tval_s2, tval_s3, tval_s4, tval_s5;
	logic [7:0] tval_s6, tval_s7, tval_s8, tval_s9, tval_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			tidx_s1 <= table_index; tidx_s2 <= tidx_s1; tidx_s3 <= tidx_s2;
			tidx_s4 <= tidx_s3; tidx_s5 <= tidx_s4; tidx_s6 <= tidx_s5;
			tidx_s7 <= tidx_s6; tidx_s8 <= tidx_s7; tidx_s9 <= tidx_s8;
			tidx_s10 <= tidx_s9;
			tval_s1 <= table_value; tval_s2 <= tval_s1; tval_s3 <= tval_s2;
			tval_s4 <= tval_s3; tval_s5 <= tval_s4; tval_s6 <= tval_s5;
			tval_s7 <= tval_s6; tval_s8 <= tval_s7; tval_s9 <= tval_s8;
			tval_s10 <= tval_s9;
		end
	end

	// ---------------- skew and cell ----------------
	logic signed [31:0] crd [NUM_DIM];
	logic signed [31:0] co_in [NUM_DIM];
	logic signed [33:0] sum_in;
	logic signed [31:0] co_s1 [NUM_DIM];
	logic signed [31:0] co_s2 [NUM_DIM];
	logic signed [31:0] co_s3 [NUM_DIM];
	logic signed [31:0] co_s4 [NUM_DIM];
	logic signed [31:0] co_s5 [NUM_DIM];
	logic signed [33:0] sum_s1;
	logic signed [63:0] prod_f;
	logic signed [33:0] skew_s2;
	logic signed [34:0] cs [NUM_DIM];
	logic signed [18:0] cell_s3 [NUM_DIM];
	logic signed [18:0] cell_s4 [NUM_DIM];
	logic signed [18:0] cell_s5 [NUM_DIM];
	logic signed [20:0] csum_s4;
	logic signed [59:0] prod_g;
	logic signed [51:0] t_s5;
	logic signed [51:0] x0w [NUM_DIM];
	logic signed [39:0] x0_s6 [NUM_DIM];
	logic [7:0] cell8_s6 [NUM_DIM];

	assign crd[0] = x_coord;
	assign crd[1] = y_coord;
	assign crd[2] = z_coord;
	assign crd[3] = w_coord;

	// drop unused coordinates and sum the rest
	always_comb begin
		for (int d = 0; d < NUM_DIM; d++) co_in[d] = use_d[d] ? crd[d] : 32'sd0;
		sum_in = 34'(co_in[0]) + 34'(co_in[1]) + 34'(co_in[2]) + 34'(co_in[3]);
	end

	always_comb begin
		prod_f = sum_s1 * $signed({1'b0, f_sel});
		for (int d = 0; d < NUM_DIM; d++) cs[d] = 35'(co_s2[d]) + 35'(skew_s2);
		prod_g = csum_s4 * $signed({1'b0, g_sel});
		for (int d = 0; d < NUM_DIM; d++) begin
			x0w[d] = 52'($signed({co_s5[d], 16'd0})) - 52'($signed({cell_s5[d], 32'd0}))
				+ t_s5;
		end
	end

	// skew, cell index, unskew and origin offset stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < NUM_DIM; d++) begin
				co_s1[d] <= co_in[d];
				co_s2[d] <= co_s1[d];
				co_s3[d] <= co_s2[d];
				co_s4[d] <= co_s3[d];
				co_s5[d] <= co_s4[d];
				cell_s3[d] <= use_d[d] ? cs[d][34:16] : 19'sd0;
				cell_s4[d] <= cell_s3[d];
				cell_s5[d] <= cell_s4[d];
				x0_s6[d] <= x0w[d][39:0];
				cell8_s6[d] <= cell_s5[d][7:0];
			end
			sum_s1 <= sum_in;
			skew_s2 <= prod_f[63:30];
			csum_s4 <= 21'(cell_s3[0]) + 21'(cell_s3[1]) + 21'(cell_s3[2]) + 21'(cell_s3[3]);
			t_s5 <= prod_g[59:8];
		end
	end

	// ---------------- rank and corner steps ----------------
	logic [1:0] rank [NUM_DIM];
	logic [3:0] step_c [NUM_CORNER];
	logic [3:0] step_s7 [NUM_CORNER];
	logic [3:0] step_s8 [NUM_CORNER];
	logic [3:0] step_s9 [NUM_CORNER];
	logic [3:0] step_s10 [NUM_CORNER];
	logic signed [39:0] x0_s7 [NUM_DIM];
	logic [7:0] cell8_s7 [NUM_DIM];
	logic [7:0] cell8_s8 [NUM_DIM];
	logic [7:0] cell8_s9 [NUM_DIM];
	logic [7:0] cell8_s10 [NUM_DIM];

	// rank the offsets: comparison tree in 3D, pairwise counts otherwise
	always_comb begin
		for (int d = 0; d < NUM_DIM; d++) rank[d] = 2'd0;
		if (sel == SEL_3D) begin
			if (x0_s6[0] >= x0_s6[1]) begin
				if (x0_s6[1] >= x0_s6[2]) begin
					rank[0] = 2'd2; rank[1] = 2'd1; rank[2] = 2'd0;
				end else if (x0_s6[0] >= x0_s6[2]) begin
					rank[0] = 2'd2; rank[1] = 2'd0; rank[2] = 2'd1;
				end else begin
					rank[0] = 2'd1; rank[1] = 2'd0; rank[2] = 2'd2;
				end
			end else begin
				if (x0_s6[1] < x0_s6[2]) begin
					rank[0] = 2'd0; rank[1] = 2'd1; rank[2] = 2'd2;
				end else if (x0_s6[0] < x0_s6[2]) begin
					rank[0] = 2'd0; rank[1] = 2'd2; rank[2] = 2'd1;
				end else begin
					rank[0] = 2'd1; rank[1] = 2'd2; rank[2] = 2'd0;
				end
			end
		end else begin
			for (int d = 0; d < NUM_DIM; d++) begin
				for (int e = 0; e < NUM_DIM; e++) begin
					if (e != d && use_d[d] && use_d[e]) begin
						if (e > d ? (x0_s6[d] > x0_s6[e]) : (x0_s6[d] >= x0_s6[e]))
							rank[d] = rank[d] + 2'd1;
					end
				end
			end
		end
		for (int k = 0; k < NUM_CORNER; k++) begin
			for (int d = 0; d < NUM_DIM; d++) begin
				step_c[k][d] = ({2'b00, rank[d]} >= (4'(n_val) - 4'(k)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_CORNER; k++) begin
				step_s7[k] <= step_c[k];
				step_s8[k] <= step_s7[k];
				step_s9[k] <= step_s8[k];
				step_s10[k] <= step_s9[k];
			end
			for (int d = 0; d < NUM_DIM; d++) begin
				x0_s7[d] <= x0_s6[d];
				cell8_s7[d] <= cell8_s6[d];
				cell8_s8[d] <= cell8_s7[d];
				cell8_s9[d] <= cell8_s8[d];
				cell8_s10[d] <= cell8_s9[d];
			end
		end
	end

	// ---------------- permutation hash ----------------
	logic [TAB_AW-1:0] ram_raddr [NUM_CORNER][NUM_LEVEL];
	logic [7:0] ram_rdata [NUM_CORNER][NUM_LEVEL];
	logic [NUM_LEVEL-1:0] ram_we;
	logic [TAB_AW-1:0] ram_waddr [NUM_LEVEL];
	logic [7:0] ram_wdata [NUM_LEVEL];
	logic [7:0] h0 [NUM_CORNER];
	logic [7:0] h1 [NUM_CORNER];
	logic [7:0] hc_s9 [NUM_CORNER];

	// a load writes each copy as it moves past that copy's read stage
	always_comb begin
		ram_we[0] = adv && vld_s7 && ld_s7;
		ram_we[1] = adv && vld_s8 && ld_s8;
		ram_we[2] = adv && vld_s9 && ld_s9;
		ram_we[3] = adv && vld_s10 && ld_s10;
		ram_waddr[0] = tidx_s7[TAB_AW-1:0];
		ram_waddr[1] = tidx_s8[TAB_AW-1:0];
		ram_waddr[2] = tidx_s9[TAB_AW-1:0];
		ram_waddr[3] = tidx_s10[TAB_AW-1:0];
		ram_wdata[0] = tval_s7;
		ram_wdata[1] = tval_s8;
		ram_wdata[2] = tval_s9;
		ram_wdata[3] = tval_s10;
	end

	// chain the hash from the last used coordinate down to x
	always_comb begin
		for (int k = 0; k < NUM_CORNER; k++) begin
			h0[k] = (sel == SEL_4D) ? ram_rdata[k][0] : 8'd0;
			h1[k] = use_d[2] ? ram_rdata[k][1] : hc_s9[k];
			ram_raddr[k][0] = TAB_AW'(cell8_s7[3] + 8'(step_s7[k][3]));
			ram_raddr[k][1] = TAB_AW'(cell8_s8[2] + 8'(step_s8[k][2]) + h0[k]);
			ram_raddr[k][2] = TAB_AW'(cell8_s9[1] + 8'(step_s9[k][1]) + h1[k]);
			ram_raddr[k][3] = TAB_AW'(cell8_s10[0] + 8'(step_s10[k][0]) + ram_rdata[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_CORNER; k++) hc_s9[k] <= h0[k];
		end
	end

	for (genvar k = 0; k < NUM_CORNER; k++) begin : g_corner_ram
		for (genvar j = 0; j < NUM_LEVEL; j++) begin : g_level_ram
			sne_ram #(
				.WIDTH(8),
				.DEPTH(TABLE_SIZE)
			) u_perm (
				.clk  (clk),
				.we   (ram_we[j]),
				.waddr(ram_waddr[j]),
				.wdata(ram_wdata[j]),
				.re   (adv),
				.raddr(ram_raddr[k][j]),
				.rdata(ram_rdata[k][j])
			);
		end
	end

	// ---------------- corner offsets ----------------
	logic signed [39:0] ks [NUM_CORNER];

	for (genvar k = 0; k < NUM_CORNER; k++) begin : g_kshift
		localparam logic [63:0] KS2 = (64'(k) * 64'(UNSKEW_G2)) >> 8;
		localparam logic [63:0] KS3 = (64'(k) * 64'(UNSKEW_G3)) >> 8;
		localparam logic [63:0] KS4 = (64'(k) * 64'(UNSKEW_G4)) >> 8;
		always_comb begin
			unique case (sel)
				SEL_2D: ks[k] = $signed(KS2[39:0]);
				SEL_3D: ks[k] = $signed(KS3[39:0]);
				default: ks[k] = $signed(KS4[39:0]);
			endcase
		end
	end

	logic signed [39:0] off_s8 [NUM_CORNER][NUM_DIM];
	logic signed [31:0] v_s9 [NUM_CORNER][NUM_DIM];
	logic signed [31:0] v_s10 [NUM_CORNER][NUM_DIM];
	logic signed [31:0] v_s11 [NUM_CORNER][NUM_DIM];
	logic oor_s9 [NUM_CORNER];
	logic oor_s10 [NUM_CORNER];
	logic [60:0] sq_s10 [NUM_CORNER][NUM_DIM];
	logic signed [63:0] sq_full [NUM_CORNER][NUM_DIM];
	logic oor_c [NUM_CORNER];
	logic [62:0] sqsum [NUM_CORNER];
	logic [59:0] ttw [NUM_CORNER];
	logic [29:0] tt_s11 [NUM_CORNER];
	logic live_s11 [NUM_CORNER];

	always_comb begin
		for (int k = 0; k < NUM_CORNER; k++) begin
			oor_c[k] = 1'b0;
			for (int d = 0; d < NUM_DIM; d++) begin
				if (use_d[d] && (off_s8[k][d] >= ONE_Q32 || off_s8[k][d] <= NEG_ONE_Q32))
					oor_c[k] = 1'b1;
				sq_full[k][d] = v_s9[k][d] * v_s9[k][d];
			end
			sqsum[k] = 63'(sq_s10[k][0]) + 63'(sq_s10[k][1]) + 63'(sq_s10[k][2])
				+ 63'(sq_s10[k][3]);
			ttw[k] = HALF_Q60[59:0] - sqsum[k][59:0];
		end
	end

	// offsets, Q.30 components, squares and falloff base
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_CORNER; k++) begin
				for (int d = 0; d < NUM_DIM; d++) begin
					off_s8[k][d] <= x0_s7[d] - (step_s7[k][d] ? ONE_Q32 : 40'sd0) + ks[k];
					v_s9[k][d] <= use_d[d] ? off_s8[k][d][33:2] : 32'sd0;
					sq_s10[k][d] <= sq_full[k][d][60:0];
					v_s10[k][d] <= v_s9[k][d];
					v_s11[k][d] <= v_s10[k][d];
				end
				oor_s9[k] <= oor_c[k];
				oor_s10[k] <= oor_s9[k];
				tt_s11[k] <= ttw[k][59:30];
				live_s11[k] <= ex_k[k] && !oor_s10[k] && (sqsum[k] < HALF_Q60);
			end
		end
	end

	// ---------------- falloff and gradient dot ----------------
	grad_t grd [NUM_CORNER];
	logic signed [33:0] dot_c [NUM_CORNER];
	logic [59:0] tsq [NUM_CORNER];
	logic [57:0] t2sq [NUM_CORNER];
	logic signed [61:0] tprod [NUM_CORNER];
	logic signed [33:0] dot_s12 [NUM_CORNER];
	logic signed [33:0] dot_s13 [NUM_CORNER];
	logic [28:0] t2_s12 [NUM_CORNER];
	logic [26:0] t4_s13 [NUM_CORNER];
	logic live_s12 [NUM_CORNER];
	logic live_s13 [NUM_CORNER];
	logic signed [41:0] term_s14 [NUM_CORNER];

	always_comb begin
		for (int k = 0; k < NUM_CORNER; k++) begin
			grd[k] = grad_lookup(ram_rdata[k][3], sel == SEL_4D);
			dot_c[k] = 34'sd0;
			for (int d = 0; d < NUM_DIM; d++) begin
				if (grd[k].nz[d]) begin
					if (grd[k].neg[d]) dot_c[k] = dot_c[k] - 34'(v_s11[k][d]);
					else dot_c[k] = dot_c[k] + 34'(v_s11[k][d]);
				end
			end
			tsq[k] = tt_s11[k] * tt_s11[k];
			t2sq[k] = t2_s12[k] * t2_s12[k];
			tprod[k] = $signed({1'b0, t4_s13[k]}) * dot_s13[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_CORNER; k++) begin
				dot_s12[k] <= dot_c[k];
				t2_s12[k] <= tsq[k][58:30];
				live_s12[k] <= live_s11[k];
				dot_s13[k] <= dot_s12[k];
				t4_s13[k] <= t2sq[k][56:30];
				live_s13[k] <= live_s12[k];
				term_s14[k] <= live_s13[k] ? tprod[k][61:20] : 42'sd0;
			end
		end
	end

	// ---------------- sum, scale and saturate ----------------
	logic signed [44:0] acc_s15;
	logic signed [52:0] sc_s16;
	logic signed [52:0] sc_c;
	logic signed [27:0] r_c;
	logic signed [15:0] sat_c;

	always_comb begin
		sc_c = acc_s15 * $signed({1'b0, scale_sel}) + 53'sd16777216;
		r_c = sc_s16[52:25];
		if (r_c > 28'sd32767) sat_c = 16'sd32767;
		else if (r_c < -28'sd32768) sat_c = -16'sd32768;
		else sat_c = r_c[15:0];
	end

	// hold the result while the output is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s15 <= 45'(term_s14[0]) + 45'(term_s14[1]) + 45'(term_s14[2])
				+ 45'(term_s14[3]) + 45'(term_s14[4]);
			sc_s16 <= sc_c;
			noise_value <= sat_c;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sne_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- verif/simplex_noise_eval_top_test.sv -----
// Self-checking testbench for the simplex noise evaluator top level.
`timescale 1ns / 1ps
`default_nettype none
module simplex_noise_eval_top_test
	import sne_pkg::*;
();

	localparam longint ONE_Q32 = 64'sd4294967296;
	localparam longint HALF_Q60 = 64'sd576460752303423488;
	localparam int DRAIN_CYCLES = 24;

	localparam int CUBE_GRAD [12][3] = '{
		'{1, 1, 0}, '{-1, 1, 0}, '{1, -1, 0}, '{-1, -1, 0}, '{1, 0, 1}, '{-1, 0, 1},
		'{1, 0, -1}, '{-1, 0, -1}, '{0, 1, 1}, '{0, -1, 1}, '{0, 1, -1}, '{0, -1, -1}};
	localparam int HYPER_GRAD [32][4] = '{
		'{0, 1, 1, 1}, '{0, 1, 1, -1}, '{0, 1, -1, 1}, '{0, 1, -1, -1},
		'{0, -1, 1, 1}, '{0, -1, 1, -1}, '{0, -1, -1, 1}, '{0, -1, -1, -1},
		'{1, 0, 1, 1}, '{1, 0, 1, -1}, '{1, 0, -1, 1}, '{1, 0, -1, -1},
		'{-1, 0, 1, 1}, '{-1, 0, 1, -1}, '{-1, 0, -1, 1}, '{-1, 0, -1, -1},
		'{1, 1, 0, 1}, '{1, 1, 0, -1}, '{1, -1, 0, 1}, '{1, -1, 0, -1},
		'{-1, 1, 0, 1}, '{-1, 1, 0, -1}, '{-1, -1, 0, 1}, '{-1, -1, 0, -1},
		'{1, 1, 1, 0}, '{1, 1, -1, 0}, '{1, -1, 1, 0}, '{1, -1, -1, 0},
		'{-1, 1, 1, 0}, '{-1, 1, -1, 0}, '{-1, -1, 1, 0}, '{-1, -1, -1, 0}};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic operation;
	logic signed [31:0] x_coord, y_coord, z_coord, w_coord;
	logic [7:0] table_index, table_value;
	logic out_valid, out_ready;
	logic signed [15:0] noise_value;

	// predictor state
	logic [7:0] perm_copy [TABLE_SIZE];
	logic [2:0] dims_copy;
	logic signed [15:0] noise_expect [$];

	int error_count;
	int eval_count;
	int load_count;
	int checked_count;
	int send_idle_pct;
	int recv_stall_pct;

	logic [31:0] dims_list [4] = '{32'd0, 32'd1, 32'd5, 32'd7};

	simplex_noise_eval_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord), .w_coord(w_coord),
		.table_index(table_index), .table_value(table_value),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// hash a lattice index through the table copy
	function automatic logic [7:0] perm_lookup(input longint idx);
		logic [7:0] a;
		a = idx[7:0];
		return perm_copy[a];
	endfunction

	// falloff contribution of one corner, Q.40
	function automatic longint corner_falloff(input longint off [4], input int n,
			input logic [7:0] h);
		longint v [4];
		longint sq, dot, tt, t2, t4;
		int g;
		sq = 0;
		dot = 0;
		for (int d = 0; d < n; d++) begin
			if (off[d] >= ONE_Q32 || off[d] <= -ONE_Q32) return 0;
			v[d] = off[d] >>> 2;
			sq += v[d] * v[d];
		end
		tt = HALF_Q60 - sq;
		if (tt <= 0) return 0;
		tt = tt >>> 30;
		t2 = (tt * tt) >>> 30;
		t4 = (t2 * t2) >>> 30;
		for (int d = 0; d < n; d++) begin
			g = (n == 4) ? HYPER_GRAD[h % 32][d] : CUBE_GRAD[h % 12][d];
			dot += longint'(g) * v[d];
		end
		return (t4 * dot) >>> 20;
	endfunction

	// expected noise sample for one point under the current dimension setting
	function automatic logic signed [15:0] noise_predict(input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz,
			input logic signed [31:0] cw);
		longint c [4];
		longint lattice [4];
		longint x0 [4];
		longint off [4];
		longint skew, unskew, sum, csum, t, s, acc, shift, r;
		int rank [4];
		int n, o, stp;
		logic [7:0] h;
		n = (dims_copy < 2) ? 2 : (dims_copy > 4) ? 4 : int'(dims_copy);
		c[0] = cx;
		c[1] = cy;
		c[2] = cz;
		c[3] = cw;
		skew = (n == 2) ? longint'(SKEW_F2) : (n == 3) ? longint'(SKEW_F3) : longint'(SKEW_F4);
		unskew = (n == 2) ? longint'(UNSKEW_G2) :
			(n == 3) ? longint'(UNSKEW_G3) : longint'(UNSKEW_G4);
		sum = 0;
		csum = 0;
		acc = 0;
		for (int d = 0; d < n; d++) sum += c[d];
		s = (sum * skew) >>> 30;
		for (int d = 0; d < n; d++) begin
			lattice[d] = (c[d] + s) >>> 16;
			csum += lattice[d];
		end
		t = (csum * unskew) >>> 8;
		for (int d = 0; d < n; d++) x0[d] = c[d] * 65536 - lattice[d] * ONE_Q32 + t;
		// rank the offsets to pick the corner walk
		for (int d = 0; d < 4; d++) rank[d] = 0;
		if (n == 3) begin
			if (x0[0] >= x0[1]) o = (x0[1] >= x0[2]) ? 0 : ((x0[0] >= x0[2]) ? 1 : 2);
			else o = (x0[1] < x0[2]) ? 3 : ((x0[0] < x0[2]) ? 4 : 5);
			case (o)
				0: begin rank[0] = 2; rank[1] = 1; rank[2] = 0; end
				1: begin rank[0] = 2; rank[1] = 0; rank[2] = 1; end
				2: begin rank[0] = 1; rank[1] = 0; rank[2] = 2; end
				3: begin rank[0] = 0; rank[1] = 1; rank[2] = 2; end
				4: begin rank[0] = 0; rank[1] = 2; rank[2] = 1; end
				default: begin rank[0] = 1; rank[1] = 2; rank[2] = 0; end
			endcase
		end else begin
			for (int d = 0; d < n; d++)
				for (int e = 0; e < n; e++)
					if (e != d && ((e > d) ? (x0[d] > x0[e]) : (x0[d] >= x0[e])))
						rank[d]++;
		end
		// walk the corners, hashing from the last coordinate down
		for (int k = 0; k <= n; k++) begin
			shift = (longint'(k) * unskew) >>> 8;
			h = 8'd0;
			for (int d = n - 1; d >= 0; d--) begin
				stp = (rank[d] >= n - k) ? 1 : 0;
				h = perm_lookup(lattice[d] + stp + h);
				off[d] = x0[d] - longint'(stp) * ONE_Q32 + shift;
			end
			acc += corner_falloff(off, n, h);
		end
		r = (acc * ((n == 2) ? 70 : (n == 3) ? 32 : 27) + (64'sd1 <<< 24)) >>> 25;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	// present one item and hold it until the transfer
	task automatic send_item(input logic op, input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz,
			input logic signed [31:0] cw, input logic [7:0] idx, input logic [7:0] val);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		x_coord <= cx;
		y_coord <= cy;
		z_coord <= cz;
		w_coord <= cw;
		table_index <= idx;
		table_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OP_LOAD) begin
			perm_copy[idx] = val;
			load_count++;
		end else begin
			noise_expect.push_back(noise_predict(cx, cy, cz, cw));
			eval_count++;
		end
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_eval(input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic signed [31:0] cz, input logic signed [31:0] cw);
		send_item(OP_EVAL, cx, cy, cz, cw, 8'($urandom), 8'($urandom));
	endtask

	// drain the pipeline, then write the dimensions register
	task automatic write_dimensions(input logic [31:0] value);
		stop_sending();
		while (noise_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		dims_copy = value[2:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (noise_expect.size() == 0) begin
				report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
			end else begin
				if (noise_value !== noise_expect[0])
					report_mismatch($sformatf("noise_value %0d, expected %0d",
						noise_value, noise_expect[0]));
				void'(noise_expect.pop_front());
				checked_count++;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
	endfunction

	// fill every table entry with a shuffled permutation
	task automatic test_table_load();
		logic [7:0] p [256];
		logic [7:0] tmp;
		int j;
		for (int i = 0; i < 256; i++) p[i] = i[7:0];
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = p[i];
			p[i] = p[j];
			p[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			send_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom, i[7:0], p[i]);
	endtask

	// field extremes and lattice points in each dimension count
	task automatic test_directed_points(input logic [31:0] dims);
		write_dimensions(dims);
		send_eval(0, 0, 0, 0);
		send_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_eval(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
		send_eval(32'h0000_8000, 32'h0001_4000, 32'hffff_c000, 32'h0000_2000);
		send_eval(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		// unused coordinates must not matter
		send_eval(32'h0003_1234, 32'hfffe_8765, 32'h7fff_ffff, 32'h8000_0000);
		send_eval(32'h0003_1234, 32'hfffe_8765, 32'h0000_0000, 32'h8000_0000);
	endtask

	// out-of-range dimension settings clamp to the nearest legal value; a table entry is rewritten
	task automatic test_dimension_range();
		foreach (dims_list[i]) begin
			write_dimensions(dims_list[i]);
			send_eval(32'h0002_3456, 32'hffff_1111, 32'h0005_9abc, 32'hfffc_0001);
		end
		send_item(OP_LOAD, 0, 0, 0, 0, 8'd17, perm_copy[17] ^ 8'hff);
		send_eval(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
	endtask

	// random points with table rewrites and dimension changes mixed in, under one idle/stall pattern
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) write_dimensions($urandom_range(2, 4));
			if ($urandom_range(0, 9) == 0)
				send_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom,
					8'($urandom), 8'($urandom));
			else
				send_eval(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		in_valid = 1'b0;
		operation = OP_EVAL;
		x_coord = 0;
		y_coord = 0;
		z_coord = 0;
		w_coord = 0;
		table_index = 8'd0;
		table_value = 8'd0;
		out_ready = 1'b1;
		dims_copy = 3'd2;
		error_count = 0;
		eval_count = 0;
		load_count = 0;
		checked_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < TABLE_SIZE; i++) perm_copy[i] = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_directed_points(32'd2);
		test_directed_points(32'd3);
		test_directed_points(32'd4);
		test_dimension_range();
		test_random_phase(0, 0, 130);
		test_random_phase(70, 0, 130);
		test_random_phase(0, 70, 130);
		test_random_phase(18, 18, 130);

		stop_sending();
		while (noise_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d evaluations and %0d table loads in 2D, 3D and 4D,",
			eval_count, load_count);
		$display("with clamped dimension settings and four idle/stall mixes; %0d checked",
			checked_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// hard stop in case the handshake hangs
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/sne_pkg.sv
hdl/sne_ram.sv
hdl/simplex_noise_eval_top.sv
verif/simplex_noise_eval_top_test.sv
